// ===== sv/srl_pkg.sv =====
// Package for the segment ring lifecycle unit: request/result structs,
// slot phase codes, function codes and status codes. No dependencies.
package srl_pkg;

  localparam int RING_DEPTH = 64;
  localparam int SLOT_W = $clog2(RING_DEPTH);
  localparam int IDX_W = 6;

  typedef enum logic [2:0] {
    FN_ALLOCATE = 3'd0,
    FN_GET_WRITE = 3'd1,
    FN_GET_READ = 3'd2,
    FN_REL_WRITE = 3'd3,
    FN_REL_READ = 3'd4,
    FN_CLOSE = 3'd5,
    FN_FREE_UP_TO = 3'd6,
    FN_UNUSED = 3'd7
  } func_t;

  typedef enum logic [1:0] {
    PH_FREE = 2'd0,
    PH_WRITING = 2'd1,
    PH_READING = 2'd2,
    PH_CLOSED = 2'd3
  } phase_t;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_REFUSED = 2'd1;
  localparam logic [1:0] ST_FAULT = 2'd2;

  localparam logic [2:0] ACT_NONE = 3'd0;
  localparam logic [2:0] ACT_CREATE = 3'd1;
  localparam logic [2:0] ACT_REOPEN = 3'd2;
  localparam logic [2:0] ACT_CLOSE = 3'd3;
  localparam logic [2:0] ACT_DESTROY = 3'd4;

  typedef struct packed {
    logic [2:0] func;
    logic [31:0] seg_no;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [IDX_W-1:0] slot_index;
    logic [31:0] tail_after;
    logic [2:0] store_action;
    logic list_empty;
    logic list_full;
  } rsp_t;

  typedef struct packed {
    phase_t phase;
    logic [15:0] refs;
    logic [31:0] seq;
  } slot_t;

  // controller -> datapath
  typedef struct packed {
    logic latch_req;
    logic rd_req;
    logic rd_tail;
    logic exec_req;
    logic exec_free;
    logic fin_free;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_free;
    logic walk_go;
    logic walk_stop;
  } dp_sts_t;

endpackage

// ===== sv/srl_datapath.sv =====
// Datapath of the segment ring lifecycle unit: slot memory, head and tail
// counters, request decode and result register. Depends on srl_pkg.
module srl_datapath
  import srl_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  req_t    req,
  input  dp_cmd_t cmd,
  output dp_sts_t sts,
  output rsp_t    rsp
);

  slot_t mem [RING_DEPTH];
  logic [RING_DEPTH-1:0] vld_r;
  slot_t rd_r;
  logic rd_vld_r;
  logic [SLOT_W-1:0] rd_addr_r;
  req_t req_r;
  logic [31:0] head_r, tail_r;
  logic any_r, wfault_r;
  rsp_t rsp_r;

  logic [SLOT_W-1:0] req_slot, tail_slot, rd_addr;
  slot_t cur, wr_data;
  logic wr_en;
  logic [SLOT_W-1:0] wr_addr;
  logic [1:0] st;
  logic [2:0] act;
  logic head_inc;
  logic live, full_now;
  logic [31:0] n;
  logic t_stop, t_fault;
  logic [31:0] tail_nxt, head_nxt;

  assign n = req_r.seg_no;
  assign req_slot = req.seg_no[SLOT_W-1:0];
  assign tail_slot = tail_r[SLOT_W-1:0];
  assign rd_addr = cmd.rd_tail ? tail_slot : req_slot;
  assign cur = rd_vld_r ? rd_r : '{PH_FREE, 16'd0, 32'd0};
  assign live = (tail_r <= n) && (n < head_r);
  assign full_now = ((head_r[SLOT_W-1:0] + SLOT_W'(1)) == tail_slot);

  always_ff @(posedge clk) begin
    if (cmd.rd_req || cmd.rd_tail) begin
      rd_r <= mem[rd_addr];
      rd_addr_r <= rd_addr;
    end
    if (wr_en) mem[wr_addr] <= wr_data;
    if (cmd.latch_req) req_r <= req;
  end

  always_comb begin
    st = ST_FAULT;
    act = ACT_NONE;
    head_inc = 1'b0;
    wr_en = 1'b0;
    wr_addr = rd_addr_r;
    wr_data = cur;
    t_stop = 1'b1;
    t_fault = 1'b0;
    if (cmd.exec_req) begin
      case (func_t'(req_r.func))
        FN_ALLOCATE: begin
          if (full_now || head_r < n) st = ST_FAULT;
          else if (head_r != n) st = ST_REFUSED;
          else if (cur.phase != PH_FREE || (cur.seq == n && n != 0)) st = ST_FAULT;
          else begin
            st = ST_OK; act = ACT_CREATE; head_inc = 1'b1; wr_en = 1'b1;
            wr_data = '{PH_WRITING, cur.refs, n};
          end
        end
        FN_GET_WRITE: begin
          if (!(n < head_r)) st = ST_FAULT;
          else if (!live || cur.phase != PH_WRITING) st = ST_REFUSED;
          else if (cur.refs == 16'hFFFF) st = ST_FAULT;
          else begin
            st = ST_OK; wr_en = 1'b1; wr_data.refs = cur.refs + 16'd1;
          end
        end
        FN_GET_READ: begin
          if (!live || cur.phase == PH_FREE) st = ST_REFUSED;
          else if (cur.phase == PH_WRITING || cur.refs == 16'hFFFF) st = ST_FAULT;
          else if (cur.phase == PH_CLOSED) begin
            if (cur.seq == n && n != 0) st = ST_FAULT;
            else begin
              st = ST_OK; act = ACT_REOPEN; wr_en = 1'b1;
              wr_data = '{PH_READING, cur.refs + 16'd1, n};
            end
          end else begin
            st = ST_OK; wr_en = 1'b1; wr_data.refs = cur.refs + 16'd1;
          end
        end
        FN_REL_WRITE, FN_REL_READ: begin
          if (!live || cur.phase != ((req_r.func == FN_REL_WRITE) ? PH_WRITING : PH_READING)
              || cur.refs == 16'd0) st = ST_FAULT;
          else begin
            st = ST_OK; wr_en = 1'b1; wr_data.refs = cur.refs - 16'd1;
          end
        end
        FN_CLOSE: begin
          if (cur.refs != 0 || cur.phase != PH_WRITING) st = ST_REFUSED;
          else if (!live || cur.seq != n) st = ST_FAULT;
          else begin
            st = ST_OK; act = ACT_CLOSE; wr_en = 1'b1;
            wr_data = '{PH_CLOSED, cur.refs, 32'd0};
          end
        end
        default: st = ST_FAULT;
      endcase
    end
    if (cmd.exec_free) begin
      if (cur.phase != PH_READING) t_fault = 1'b1;
      else if (cur.refs != 0) t_fault = 1'b0;
      else if (!(tail_r < head_r) || cur.seq != tail_r) t_fault = 1'b1;
      else begin
        t_stop = 1'b0; wr_en = 1'b1; wr_data = '{PH_FREE, 16'd0, 32'd0};
      end
    end
  end

  assign tail_nxt = tail_r + ((cmd.exec_free && !t_stop) ? 32'd1 : 32'd0);
  assign head_nxt = head_r + (head_inc ? 32'd1 : 32'd0);

  assign sts.is_free = (func_t'(req_r.func) == FN_FREE_UP_TO);
  assign sts.walk_go = (tail_r <= n) && (head_r != tail_r);
  assign sts.walk_stop = t_stop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      rd_vld_r <= 1'b0;
      head_r <= '0;
      tail_r <= '0;
      any_r <= 1'b0;
      wfault_r <= 1'b0;
    end else begin
      if (cmd.rd_req || cmd.rd_tail) rd_vld_r <= vld_r[rd_addr];
      if (wr_en) vld_r[wr_addr] <= 1'b1;
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      if (cmd.latch_req) begin
        any_r <= 1'b0;
        wfault_r <= 1'b0;
      end
      if (cmd.exec_free) begin
        if (!t_stop) any_r <= 1'b1;
        if (t_fault) wfault_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec_req) begin
      rsp_r.status <= st;
      rsp_r.slot_index <= (st == ST_OK) ? IDX_W'(n[SLOT_W-1:0]) : '0;
      rsp_r.tail_after <= '0;
      rsp_r.store_action <= act;
      rsp_r.list_empty <= (head_nxt == tail_r);
      rsp_r.list_full <= ((head_nxt[SLOT_W-1:0] + SLOT_W'(1)) == tail_slot);
    end else if (cmd.fin_free) begin
      rsp_r.status <= wfault_r ? ST_FAULT : ST_OK;
      rsp_r.slot_index <= wfault_r ? '0 : IDX_W'(n[SLOT_W-1:0]);
      rsp_r.tail_after <= tail_r;
      rsp_r.store_action <= any_r ? ACT_DESTROY : ACT_NONE;
      rsp_r.list_empty <= (head_r == tail_r);
      rsp_r.list_full <= full_now;
    end
  end

  assign rsp = rsp_r;

`ifndef ASSERT_OFF
  a_one_exec: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.exec_req && cmd.exec_free)) else $error("exec overlap");
  a_tail_le: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec_free && !t_stop |-> tail_r != head_r) else $error("free past head");
  a_head_step: assert property (@(posedge clk) disable iff (!rst_n)
    head_r != $past(head_r) |-> $past(cmd.exec_req)) else $error("head moved");
`endif

endmodule

// ===== sv/srl_ctrl.sv =====
// Controller of the segment ring lifecycle unit: sequences slot reads,
// updates, the free walk and the result handshake. Depends on srl_pkg.
module srl_ctrl
  import srl_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  typedef enum logic [2:0] {S_IDLE, S_EXEC, S_WCHK, S_WEXEC, S_WFIN} state_t;
  state_t state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;

  assign in_ready = (state_r == S_IDLE) && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd = '0;
    case (state_r)
      S_IDLE: if (in_valid && in_ready) begin
        cmd.latch_req = 1'b1;
        cmd.rd_req = 1'b1;
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (sts.is_free) state_nxt = S_WCHK;
        else begin
          cmd.exec_req = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_WCHK: begin
        if (sts.walk_go) begin
          cmd.rd_tail = 1'b1;
          state_nxt = S_WEXEC;
        end else state_nxt = S_WFIN;
      end
      S_WEXEC: begin
        cmd.exec_free = 1'b1;
        state_nxt = sts.walk_stop ? S_WFIN : S_WCHK;
      end
      S_WFIN: begin
        cmd.fin_free = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_IDLE |-> !in_ready) else $error("ready while busy");
  a_result: assert property (@(posedge clk) disable iff (!rst_n)
    $past(state_r == S_WFIN) |-> out_valid) else $error("result lost");
  a_seq: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_WEXEC |-> $past(state_r == S_WCHK)) else $error("walk order");
`endif

endmodule

// ===== sv/segment_ring_lifecycle_unit.sv =====
// Top level of the segment ring lifecycle unit: joins controller and
// datapath. Depends on srl_pkg, srl_ctrl and srl_datapath.
//
// A request first reads its slot memory, then does a read-modify-write and
// result register load. free_up_to instead walks from the tail, reading and
// updating one tail slot per step through the single slot memory, until it
// reaches the named number, an empty ring or a slot it cannot free, then
// loads the result register. One request is in flight at a time; the input
// is ready only while idle and once the previous result is taken or being
// taken. No clearing pass: slots read as free until first written.
module segment_ring_lifecycle_unit
  import srl_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  req_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output rsp_t out_data
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  srl_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready, .sts, .cmd
  );

  srl_datapath u_dp (
    .clk, .rst_n, .req(in_data), .cmd, .sts, .rsp(out_data)
  );

endmodule
